[design/si2dec_pkg.sv]
// Package for the signed integer to decimal ASCII converter.
// Holds widths, digit counts and character codes; no dependencies.
`default_nettype none

package si2dec_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned CountWidth = $clog2(ValueWidth);
  localparam int unsigned PtrWidth   = $clog2(NumDigits);

  localparam logic [CharWidth-1:0] AsciiZero  = 8'd48;
  localparam logic [CharWidth-1:0] AsciiNine  = 8'd57;
  localparam logic [CharWidth-1:0] AsciiMinus = 8'd45;

  localparam logic [PtrWidth-1:0] TopDigit = PtrWidth'(NumDigits - 1);

  typedef logic [3:0] bcd_digit_t;
  typedef bcd_digit_t bcd_vec_t [NumDigits];

  // Double-dabble correction: bias a digit of five or more by three.
  function automatic bcd_digit_t add3(input bcd_digit_t d);
    bcd_digit_t r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage

`default_nettype wire

[design/signed_int_to_decimal_ascii.sv]
// Top level: signed 32-bit integer to decimal ASCII text, one character per output transfer.
// Depends on si2dec_pkg for widths, character codes and the BCD correction.
`default_nettype none

// Takes one signed 32-bit value and sends its decimal text, most significant
// character first, with a leading '-' for negative values and no leading zeros;
// the most negative value gives "-2147483648". tlast marks the final character.
// Each item is accepted, then converted by the shift-and-add-3 BCD unit (one
// bit of the magnitude per cycle); leading zero digits are then dropped, a
// '-' is sent for a negative value, and the digits follow while the output is
// not stalled. The input is not ready until the last character of the
// previous item has been loaded into the output register.
module signed_int_to_decimal_ascii (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value (signed)
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] character
  output logic             m_tlast    // last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t                                    state;
  logic [si2dec_pkg::ValueWidth-1:0]         mag;
  si2dec_pkg::bcd_vec_t                      bcd;
  si2dec_pkg::bcd_vec_t                      bcd_next;
  logic [si2dec_pkg::CountWidth-1:0]         count;
  logic [si2dec_pkg::PtrWidth-1:0]           ptr;
  logic                                      neg;
  logic                                      out_free;
  logic                                      load;
  si2dec_pkg::bcd_digit_t                    cur_digit;
  si2dec_pkg::bcd_digit_t                    corr [si2dec_pkg::NumDigits];

  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign load      = out_free && (state == ST_SIGN || state == ST_DIGIT);
  assign cur_digit = bcd[ptr];

  // Shared BCD unit: correct every digit, then shift the whole word left one bit.
  always_comb begin
    for (int i = 0; i < int'(si2dec_pkg::NumDigits); i++) begin
      corr[i] = si2dec_pkg::add3(bcd[i]);
    end
    for (int i = 0; i < int'(si2dec_pkg::NumDigits); i++) begin
      if (i == 0) begin
        bcd_next[i] = {corr[i][2:0], mag[si2dec_pkg::ValueWidth-1]};
      end else begin
        bcd_next[i] = {corr[i][2:0], corr[i-1][3]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      ptr      <= '0;
      neg      <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            neg   <= s_tdata[si2dec_pkg::ValueWidth-1];
            mag   <= s_tdata[si2dec_pkg::ValueWidth-1] ? (32'd0 - s_tdata) : s_tdata;
            count <= '0;
            for (int i = 0; i < int'(si2dec_pkg::NumDigits); i++) begin
              bcd[i] <= '0;
            end
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd   <= bcd_next;
          mag   <= {mag[si2dec_pkg::ValueWidth-2:0], 1'b0};
          count <= count + 1'b1;
          if (count == {si2dec_pkg::CountWidth{1'b1}}) begin
            ptr   <= si2dec_pkg::TopDigit;
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // Drop leading zeros, but always keep the ones digit.
          if (cur_digit == '0 && ptr != '0) begin
            ptr <= ptr - 1'b1;
          end else begin
            state <= neg ? ST_SIGN : ST_DIGIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            m_tdata  <= si2dec_pkg::AsciiMinus;
            m_tlast  <= 1'b0;
            state    <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (out_free) begin
            m_tdata  <= si2dec_pkg::AsciiZero + {4'd0, cur_digit};
            m_tlast  <= (ptr == '0);
            if (ptr == '0) begin
              state <= ST_IDLE;
            end else begin
              ptr <= ptr - 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A minus sign never ends a run.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata == si2dec_pkg::AsciiMinus) |-> !m_tlast)
    else $error("minus sign marked as last character");

  // Only '-' or a decimal digit ever leaves the block.
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == si2dec_pkg::AsciiMinus ||
                  (m_tdata >= si2dec_pkg::AsciiZero && m_tdata <= si2dec_pkg::AsciiNine)))
    else $error("illegal output character");

  // The BCD unit finishes after exactly one pass over the magnitude bits.
  a_conv_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV && count == {si2dec_pkg::CountWidth{1'b1}}) |=> state == ST_SKIP)
    else $error("conversion did not end after the last bit");

  // After conversion every digit is a valid decimal digit.
  a_digit_bcd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP || state == ST_DIGIT) |-> cur_digit <= 4'd9)
    else $error("BCD digit out of range");

endmodule

`default_nettype wire
